/* sv/mmr_pkg.sv */
// Shared types and constants for the matrix multiply rows unit.
package mmr_pkg;

  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W = 4;
  localparam int IN_ELEM_W = 16;
  localparam int ACC_W = 48;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

  typedef struct packed {
    logic [1:0] cmd;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic signed [IN_ELEM_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_col;
    logic signed [ACC_W-1:0] out_value;
    logic bad_row;
    logic last;
  } out_item_t;

  // Control that travels alongside one multiply-accumulate step.
  typedef struct packed {
    logic valid;
    logic first;
    logic last_k;
    logic [IDX_W-1:0] col;
    logic last_col;
  } mac_tag_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_BAD
  } state_t;

endpackage

/* sv/mmr_mac.sv */
// Shared multiply-accumulate unit: product register, then accumulator.
module mmr_mac
  import mmr_pkg::*;
#(
  parameter int ELEM_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  mac_tag_t in_tag,
  input  logic signed [ELEM_WIDTH-1:0] a_elem,
  input  logic signed [ELEM_WIDTH-1:0] b_elem,
  output mac_tag_t out_tag,
  output logic signed [ACC_W-1:0] sum
);

  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] base;
  mac_tag_t tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else if (adv) begin
      tag.valid <= in_tag.valid;
    end
    if (adv) begin
      prod <= a_elem * b_elem;
      tag.first <= in_tag.first;
      tag.last_k <= in_tag.last_k;
      tag.col <= in_tag.col;
      tag.last_col <= in_tag.last_col;
    end
  end

  // Restart the sum on the first step of each column.
  always_comb begin
    base = tag.first ? '0 : acc;
    sum = base + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (adv && tag.valid) begin
      acc <= sum;
    end
  end

  assign out_tag = tag;

endmodule

/* sv/matrix_multiply_rows_unit.sv */
// Top level of the matrix multiply rows unit: stores, sequencer and result register.
// Computes rows of C = A x B. A load item writes one element of A or B; loads outside
// the configured sizes are dropped. A compute item for a valid row runs one
// multiply-accumulate unit over cols_b x inner_dim steps, one step per cycle while
// the result side does not stall, fed by one registered read port on each store;
// the block stalls its input until the read, multiply and accumulate stages drain,
// and results leave in column order with last on the final one. A compute for a row
// at or beyond rows_a yields a single item flagged bad_row. Back-pressure
// on the result side freezes the whole pipeline. Register values of zero act as one
// and values above MAX_DIM act as MAX_DIM. Store entries are undefined until loaded.
module matrix_multiply_rows_unit
  import mmr_pkg::*;
#(
  parameter int MAX_DIM = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic item_valid,
  output logic item_stall,
  input  in_item_t item,
  output logic result_valid,
  input  logic result_stall,
  output out_item_t result
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_dim;
  logic [CFG_W-1:0] cols_b;
  logic [CFG_W-1:0] n_rows;
  logic [CFG_W-1:0] n_inner;
  logic [CFG_W-1:0] n_cols;

  logic signed [ELEM_WIDTH-1:0] a_mem [STORE_DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [STORE_DEPTH];
  logic signed [ELEM_WIDTH-1:0] a_rd;
  logic signed [ELEM_WIDTH-1:0] b_rd;

  state_t state;
  state_t state_next;
  logic [CFG_W-1:0] k;
  logic [CFG_W-1:0] k_next;
  logic [CFG_W-1:0] j;
  logic [CFG_W-1:0] j_next;
  logic [IDX_W-1:0] row;

  logic accept;
  logic adv;
  logic is_load_a;
  logic is_load_b;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic signed [ELEM_WIDTH-1:0] wr_elem;
  logic last_k;
  logic last_j;

  mac_tag_t tag0;
  mac_tag_t tag1;
  mac_tag_t mac_tag;
  logic signed [ACC_W-1:0] mac_sum;

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] d;
    if (r == '0) begin
      d = CFG_W'(1);
    end else if (int'(r) > MAX_DIM) begin
      d = CFG_W'(MAX_DIM);
    end else begin
      d = r;
    end
    return d;
  endfunction

  assign n_rows = eff_dim(rows_a);
  assign n_inner = eff_dim(inner_dim);
  assign n_cols = eff_dim(cols_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS_A: rows_a <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B: cols_b <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item_stall = (state != S_IDLE);
  assign accept = item_valid && !item_stall;
  assign adv = !result_valid || !result_stall;

  // Load range checks against the active sizes.
  assign is_load_a = accept && (item.cmd == CMD_LOAD_A) &&
                     ({1'b0, item.row_index} < n_rows) &&
                     ({1'b0, item.col_index} < n_inner);
  assign is_load_b = accept && (item.cmd == CMD_LOAD_B) &&
                     ({1'b0, item.row_index} < n_inner) &&
                     ({1'b0, item.col_index} < n_cols);

  assign wr_addr = ADDR_W'(item.row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(item.col_index);
  assign wr_elem = ELEM_WIDTH'(item.element_value);
  assign a_raddr = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(k);
  assign b_raddr = ADDR_W'(k) * ADDR_W'(MAX_DIM) + ADDR_W'(j);

  always_ff @(posedge clk) begin
    if (is_load_a) begin
      a_mem[wr_addr] <= wr_elem;
    end
    if (adv) begin
      a_rd <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (is_load_b) begin
      b_mem[wr_addr] <= wr_elem;
    end
    if (adv) begin
      b_rd <= b_mem[b_raddr];
    end
  end

  assign last_k = (k == n_inner - CFG_W'(1));
  assign last_j = (j == n_cols - CFG_W'(1));

  always_comb begin
    tag0.valid = (state == S_ISSUE);
    tag0.first = (k == '0);
    tag0.last_k = last_k;
    tag0.col = j[IDX_W-1:0];
    tag0.last_col = last_j;
  end

  always_comb begin
    state_next = state;
    k_next = k;
    j_next = j;
    unique case (state)
      S_IDLE: begin
        k_next = '0;
        j_next = '0;
        if (accept && (item.cmd == CMD_COMPUTE)) begin
          if ({1'b0, item.row_index} < n_rows) begin
            state_next = S_ISSUE;
          end else begin
            state_next = S_BAD;
          end
        end
      end
      S_ISSUE: begin
        if (adv) begin
          if (last_k) begin
            k_next = '0;
            if (last_j) begin
              state_next = S_DRAIN;
            end else begin
              j_next = j + CFG_W'(1);
            end
          end else begin
            k_next = k + CFG_W'(1);
          end
        end
      end
      S_DRAIN: begin
        if (!tag1.valid && !mac_tag.valid) begin
          state_next = S_IDLE;
        end
      end
      S_BAD: begin
        if (adv) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
      j <= '0;
    end else begin
      state <= state_next;
      k <= k_next;
      j <= j_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row <= item.row_index;
    end
  end

  // Read-data stage tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
    end else if (adv) begin
      tag1.valid <= tag0.valid;
    end
    if (adv) begin
      tag1.first <= tag0.first;
      tag1.last_k <= tag0.last_k;
      tag1.col <= tag0.col;
      tag1.last_col <= tag0.last_col;
    end
  end

  mmr_mac #(
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_mac (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_tag(tag1),
    .a_elem(a_rd),
    .b_elem(b_rd),
    .out_tag(mac_tag),
    .sum(mac_sum)
  );

  // Result register: a finished column or a bad-row item enters when the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= (mac_tag.valid && mac_tag.last_k) || (state == S_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (state == S_BAD) begin
        result.out_col <= '0;
        result.out_value <= '0;
        result.bad_row <= 1'b1;
        result.last <= 1'b1;
      end else if (mac_tag.valid && mac_tag.last_k) begin
        result.out_col <= mac_tag.col;
        result.out_value <= mac_sum;
        result.bad_row <= 1'b0;
        result.last <= mac_tag.last_col;
      end
    end
  end

endmodule
